// ===== design/lsab_pkg.sv =====
package lsab_pkg;

  // Field and register widths
  localparam int BEAM_CNT_W = 7;
  localparam int TOL_W      = 6;
  localparam int ANGLE_W    = 9;
  localparam int DIST_W     = 16;
  localparam int SLOT_W     = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_BEAMS_DEF = 64;

  localparam logic [BEAM_CNT_W-1:0] BEAM_CNT_RST = 7'd32;
  localparam logic [TOL_W-1:0]      TOL_RST      = 6'd5;
  // "no previous angle" marker
  localparam logic [ANGLE_W-1:0]    ANGLE_NONE   = 9'd500;

  localparam int DEG_FULL = 360;
  localparam int DEG_HALF = 180;

  localparam int QUEUE_DEPTH    = 2;
  // quotient bits resolved per divider cycle
  localparam int DIV_RADIX_BITS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_COUNT = 1'b0,
    CFG_ANGLE_TOL  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } eng_state_e;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
  } reading_t;

  typedef struct packed {
    logic     valid;
    reading_t data;
  } queue_out_t;

endpackage

// ===== design/lsab_queue.sv =====
module lsab_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  lsab_pkg::reading_t    push_data_i,
  input  logic                  pop_i,
  output lsab_pkg::queue_out_t  head_o
);

  localparam int Depth = lsab_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lsab_pkg::reading_t entry_q [Depth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;
  logic               push;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign push         = push_valid_i && push_ready_o;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/lsab_div.sv =====
module lsab_div #(
  parameter int NumW = 15,
  parameter int DenW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] numer_i,
  input  logic [DenW-1:0] denom_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int Bits  = lsab_pkg::DIV_RADIX_BITS;
  localparam int Steps = (NumW + Bits - 1) / Bits;
  localparam int PadW  = Steps * Bits;
  localparam int StW   = $clog2(Steps + 1);

  logic [PadW-1:0] work_q, work_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [StW-1:0]  step_q;
  logic            done_q;

  // restoring division, Bits quotient bits per cycle; quotient shifts in
  // behind the numerator bits
  always_comb begin
    logic [DenW:0]   r;
    logic [PadW-1:0] w;
    r = {1'b0, rem_q};
    w = work_q;
    for (int i = 0; i < Bits; i++) begin
      r = {r[DenW-1:0], w[PadW-1]};
      w = {w[PadW-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r    = r - {1'b0, den_q};
        w[0] = 1'b1;
      end
    end
    rem_d  = r[DenW-1:0];
    work_d = w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= StW'(Steps);
      end else if (step_q != '0) begin
        step_q <= step_q - StW'(1);
        if (step_q == StW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PadW'(numer_i);
      rem_q  <= '0;
      den_q  <= denom_i;
    end else if (step_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q[NumW-1:0];

endmodule

// ===== design/lsab_engine.sv =====
module lsab_engine #(
  parameter int MaxBeams = lsab_pkg::MAX_BEAMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lsab_pkg::BEAM_CNT_W-1:0] beam_count_i,
  input  logic [lsab_pkg::TOL_W-1:0]      angle_tol_i,
  input  lsab_pkg::queue_out_t            head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lsab_pkg::SLOT_W-1:0]     slot_number_o,
  output logic [lsab_pkg::DIST_W-1:0]     slot_distance_o,
  output logic                            last_of_scan_o
);

  localparam int CntW = $clog2(MaxBeams + 1);
  localparam int IdxW = (MaxBeams > 1) ? $clog2(MaxBeams) : 1;
  localparam int NumW = $clog2(MaxBeams * lsab_pkg::DEG_FULL + 1);
  localparam int EvW  = NumW + 1;
  localparam int AW   = lsab_pkg::ANGLE_W;
  localparam int DW   = lsab_pkg::DIST_W;

  lsab_pkg::eng_state_e state_q, state_d;

  logic [CntW-1:0]    count;
  logic [CntW-1:0]    slot_q, slot_d, slot_p1, slot_adv, slot_mask;
  logic [AW-1:0]      prev_q, prev_d;
  lsab_pkg::reading_t item_q;

  // divider
  logic               div_start, div_done;
  logic [NumW-1:0]    div_numer, div_quot;

  // evaluation
  logic [EvW-1:0]     ev_angle, ev_tol, ev_tgt, dt_full;
  logic               in_win, in_win_q;
  logic [AW-1:0]      dt_q, dp, dp_q, d9;
  logic               closer, do_store, do_adv, do_emit;

  // scan store
  logic [DW-1:0]      store_mem [MaxBeams];
  logic [MaxBeams-1:0] vld_q;
  logic [IdxW-1:0]    widx, raddr;

  // emission
  logic [CntW-1:0]    k_q, k_d;
  logic               k_last, issue, move;
  logic               pend_q, rvld_q, rlast_q;
  logic [DW-1:0]      rdata_q;
  logic [lsab_pkg::SLOT_W-1:0] rslot_q;
  logic               out_v_q;
  logic [lsab_pkg::SLOT_W-1:0] out_slot_q;
  logic [DW-1:0]      out_dist_q;
  logic               out_last_q;

  always_comb begin
    if (beam_count_i == '0) begin
      count = CntW'(1);
    end else if (beam_count_i > (lsab_pkg::BEAM_CNT_W)'(MaxBeams)) begin
      count = CntW'(MaxBeams);
    end else begin
      count = beam_count_i[CntW-1:0];
    end
  end

  // target = floor((slot+1)*360/count)
  assign slot_p1   = slot_q + CntW'(1);
  assign div_numer = NumW'(slot_p1) * NumW'(lsab_pkg::DEG_FULL);

  lsab_div #(
    .NumW (NumW),
    .DenW (CntW)
  ) u_lsab_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (count),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // window test and angular distances
  assign ev_angle = EvW'(item_q.angle);
  assign ev_tol   = EvW'(angle_tol_i);
  assign ev_tgt   = EvW'(div_quot);
  assign in_win   = (ev_angle + ev_tol > ev_tgt) && (ev_angle < ev_tgt + ev_tol);
  // inside the window this is below 64, so no wrap and 9 bits suffice
  assign dt_full  = (ev_tgt > ev_angle) ? ev_tgt - ev_angle : ev_angle - ev_tgt;

  assign d9 = (prev_q > item_q.angle) ? prev_q - item_q.angle : item_q.angle - prev_q;
  always_comb begin
    if (d9 > AW'(lsab_pkg::DEG_HALF)) begin
      dp = (d9 <= AW'(lsab_pkg::DEG_FULL)) ? AW'(lsab_pkg::DEG_FULL) - d9
                                           : d9 - AW'(lsab_pkg::DEG_FULL);
    end else begin
      dp = d9;
    end
  end

  assign closer   = dt_q < dp_q;
  assign do_store = in_win_q && closer;
  assign do_adv   = in_win_q && !closer;
  assign slot_adv = do_adv ? slot_p1 : slot_q;
  assign do_emit  = slot_adv >= count;

  assign slot_mask = slot_q & CntW'(MaxBeams - 1);
  assign widx      = slot_mask[IdxW-1:0];

  // emission read pipeline: issue -> read register -> output register
  assign raddr  = k_q[IdxW-1:0];
  assign k_last = (k_q == count - CntW'(1));
  assign move   = pend_q && (!out_v_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsab_pkg::ST_IDLE: begin
        if (head_i.valid) state_d = lsab_pkg::ST_DIV;
      end
      lsab_pkg::ST_DIV: begin
        if (div_done) state_d = lsab_pkg::ST_APPLY;
      end
      lsab_pkg::ST_APPLY: begin
        state_d = do_emit ? lsab_pkg::ST_EMIT : lsab_pkg::ST_IDLE;
      end
      lsab_pkg::ST_EMIT: begin
        if (issue && k_last) state_d = lsab_pkg::ST_IDLE;
      end
      default: state_d = lsab_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    issue     = 1'b0;
    case (state_q)
      lsab_pkg::ST_IDLE: begin
        pop_o     = head_i.valid;
        div_start = head_i.valid;
      end
      lsab_pkg::ST_EMIT: begin
        issue = !pend_q || move;
      end
      default: ;
    endcase
  end

  always_comb begin
    slot_d = slot_q;
    prev_d = prev_q;
    k_d    = k_q;
    case (state_q)
      lsab_pkg::ST_APPLY: begin
        if (do_emit) begin
          slot_d = '0;
          prev_d = lsab_pkg::ANGLE_NONE;
          k_d    = '0;
        end else begin
          slot_d = slot_adv;
          if (do_store) prev_d = item_q.angle;
        end
      end
      lsab_pkg::ST_EMIT: begin
        if (issue) k_d = k_q + CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsab_pkg::ST_IDLE;
      slot_q  <= '0;
      prev_q  <= lsab_pkg::ANGLE_NONE;
      k_q     <= '0;
      vld_q   <= '0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      prev_q  <= prev_d;
      k_q     <= k_d;
      if (state_q == lsab_pkg::ST_APPLY && do_store) begin
        vld_q[widx] <= 1'b1;
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i.data;
    end
    if (state_q == lsab_pkg::ST_DIV && div_done) begin
      in_win_q <= in_win;
      dt_q     <= dt_full[AW-1:0];
      dp_q     <= dp;
    end
    if (state_q == lsab_pkg::ST_APPLY && do_store) begin
      store_mem[widx] <= item_q.distance;
    end
    if (issue) begin
      rdata_q <= store_mem[raddr];
      rvld_q  <= vld_q[raddr];
      rslot_q <= (lsab_pkg::SLOT_W)'(k_q);
      rlast_q <= k_last;
    end
    if (move) begin
      out_dist_q <= rvld_q ? rdata_q : '0;
      out_slot_q <= rslot_q;
      out_last_q <= rlast_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign slot_number_o   = out_slot_q;
  assign slot_distance_o = out_dist_q;
  assign last_of_scan_o  = out_last_q;

endmodule

// ===== design/lidar_scan_angle_binner_top.sv =====
// Lidar scan angle binner.
//
// Readings (angle in degrees, distance) enter on the in_* valid/ready channel.
// Each accepted word waits in a two-entry queue, then the back end computes
// the current slot's target angle floor((slot+1)*360/count) on an iterative
// divider, checks the tolerance window and, inside it, either stores the
// distance for the slot or advances to the next slot. When the slot index
// reaches the beam count, the whole scan goes out on the result_* channel:
// one word per slot, slots 0..count-1 in order, last_of_scan_o set on the last.
// The back end handles one reading at a time: pop and divider start, divider
// steps at 4 quotient bits each, window evaluation, store/advance.
// A scan burst passes the read register and the output register after the
// decision and then runs at one word per cycle while result_ready_i is high.
// A receiver stall holds the output word; the queue keeps taking readings
// until it is full, then in_ready_o drops.
// Reset clears the queue, slot index and previous angle, marks every slot as
// unwritten (reads as zero distance) and loads beam_count = 32, tolerance = 5.
// Config writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once and
// are to be issued only while the block is idle.
module lidar_scan_angle_binner_top #(
  parameter int MAX_BEAMS = lsab_pkg::MAX_BEAMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsab_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lsab_pkg::ANGLE_W-1:0]    reading_angle_i,
  input  logic [lsab_pkg::DIST_W-1:0]     reading_distance_i,
  output logic                            result_valid_o,
  input  logic                            result_ready_i,
  output logic [lsab_pkg::SLOT_W-1:0]     slot_number_o,
  output logic [lsab_pkg::DIST_W-1:0]     slot_distance_o,
  output logic                            last_of_scan_o
);

  logic [lsab_pkg::BEAM_CNT_W-1:0] beam_count_q;
  logic [lsab_pkg::TOL_W-1:0]      angle_tol_q;

  lsab_pkg::reading_t   in_word;
  lsab_pkg::queue_out_t head;
  logic                 pop;

  // config registers; no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_count_q <= lsab_pkg::BEAM_CNT_RST;
      angle_tol_q  <= lsab_pkg::TOL_RST;
    end else if (cfg_we_i) begin
      case (lsab_pkg::cfg_reg_e'(cfg_index_i))
        lsab_pkg::CFG_BEAM_COUNT: beam_count_q <= cfg_data_i;
        lsab_pkg::CFG_ANGLE_TOL:  angle_tol_q  <= cfg_data_i[lsab_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_word.angle    = reading_angle_i;
  assign in_word.distance = reading_distance_i;

  // front: input queue decouples the reading source from the slot engine
  lsab_queue u_lsab_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (in_word),
    .pop_i        (pop),
    .head_o       (head)
  );

  // back: target division, window decision, scan store and emission
  lsab_engine #(
    .MaxBeams (MAX_BEAMS)
  ) u_lsab_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beam_count_i    (beam_count_q),
    .angle_tol_i     (angle_tol_q),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (result_valid_o),
    .out_ready_i     (result_ready_i),
    .slot_number_o   (slot_number_o),
    .slot_distance_o (slot_distance_o),
    .last_of_scan_o  (last_of_scan_o)
  );

endmodule

// ===== design/lsab_checker.sv =====
module lsab_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            result_valid_o,
  input logic                            result_ready_i,
  input logic [lsab_pkg::SLOT_W-1:0]     slot_number_o,
  input logic [lsab_pkg::DIST_W-1:0]     slot_distance_o,
  input logic                            last_of_scan_o
);

  logic [lsab_pkg::SLOT_W-1:0] exp_slot_q;

  // slot number expected on the next result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_slot_q <= '0;
    end else if (result_valid_o && result_ready_i) begin
      exp_slot_q <= last_of_scan_o ? '0 : exp_slot_q + (lsab_pkg::SLOT_W)'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(slot_number_o)
      && $stable(slot_distance_o) && $stable(last_of_scan_o))
    else $error("result word changed while stalled");

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> slot_number_o == exp_slot_q)
    else $error("scan slots out of order");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !result_valid_o)
    else $error("result valid during reset");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i && slot_number_o == {lsab_pkg::SLOT_W{1'b1}}
      |-> last_of_scan_o)
    else $error("scan longer than slot range");

endmodule

bind lidar_scan_angle_binner_top lsab_checker u_lsab_checker (.*);

// ===== sim/tb_lidar_scan_angle_binner_top.sv =====
module tb_lidar_scan_angle_binner_top;
  import lsab_pkg::*;

  // The settle wait covers any reading still in flight that emits nothing: the
  // one in the back end and up to two more held in the queue.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int SWEEP_GUARD   = 300;
  localparam int TIMEOUT_UNITS = 2000000;

  // One result word as the block emits it.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] distance;
    logic              last;
  } bin_word_t;

  typedef enum logic [1:0] {
    ROW_CFG,    // register write, issued once the block is idle
    ROW_READ,   // reading, checked against the predictor
    ROW_KNOWN   // reading whose single-slot scan word is typed in below
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    cfg_reg_e                reg_sel;
    logic [CFG_DATA_W-1:0]   value;
    logic [ANGLE_W-1:0]      angle;
    logic [DIST_W-1:0]       distance;
    bin_word_t               known;
  } dir_row_t;

  localparam bin_word_t NO_WORD = '0;
  localparam int N_DIR = 25;

  // Directed part. Starts at reset settings (32 slots, tolerance 5).
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    // reset config: slot 0 target 11, stored
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd11,  16'h0000, NO_WORD},
    // single slot, target 360: store then advance emits one word
    '{ROW_CFG,   CFG_BEAM_COUNT, 7'd1,   9'd0,   16'h0000, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd360, 16'hFFFF, NO_WORD},
    '{ROW_KNOWN, CFG_BEAM_COUNT, 7'd0,   9'd360, 16'h1234, '{6'd0, 16'hFFFF, 1'b1}},
    // zero count acts as one slot; window edges near 360 are not wrapped
    '{ROW_CFG,   CFG_BEAM_COUNT, 7'd0,   9'd0,   16'h0000, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd354, 16'h5555, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd364, 16'hAAAA, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd356, 16'h0001, NO_WORD},
    // angle above 359 taken as is, lands outside
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd511, 16'h7E7E, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd360, 16'h0002, NO_WORD},
    '{ROW_KNOWN, CFG_BEAM_COUNT, 7'd0,   9'd360, 16'h0003, '{6'd0, 16'h0002, 1'b1}},
    // zero tolerance: empty window, nothing moves
    '{ROW_CFG,   CFG_ANGLE_TOL,  7'd0,   9'd0,   16'h0000, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd360, 16'h7777, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd0,   16'hFFFF, NO_WORD},
    // 45-degree window, count saturated to 64, walk three slots
    '{ROW_CFG,   CFG_ANGLE_TOL,  7'd45,  9'd0,   16'h0000, NO_WORD},
    '{ROW_CFG,   CFG_BEAM_COUNT, 7'd100, 9'd0,   16'h0000, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd0,   16'hFFFF, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd5,   16'h8001, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd5,   16'h1111, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd11,  16'h2222, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd11,  16'h3333, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd16,  16'h4444, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd16,  16'h5555, NO_WORD},
    // count lowered below the slot index: next reading flushes the scan
    '{ROW_CFG,   CFG_BEAM_COUNT, 7'd2,   9'd0,   16'h0000, NO_WORD},
    '{ROW_READ,  CFG_BEAM_COUNT, 7'd0,   9'd300, 16'h0F0F, NO_WORD}
  };

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i        = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i         = '0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_ready_o;
  logic [ANGLE_W-1:0]    reading_angle_i    = '0;
  logic [DIST_W-1:0]     reading_distance_i = '0;
  logic                  result_valid_o;
  logic                  result_ready_i     = 1'b0;
  logic [SLOT_W-1:0]     slot_number_o;
  logic [DIST_W-1:0]     slot_distance_o;
  logic                  last_of_scan_o;

  lidar_scan_angle_binner_top #(
    .MAX_BEAMS(MAX_BEAMS_DEF)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .reading_angle_i   (reading_angle_i),
    .reading_distance_i(reading_distance_i),
    .result_valid_o    (result_valid_o),
    .result_ready_i    (result_ready_i),
    .slot_number_o     (slot_number_o),
    .slot_distance_o   (slot_distance_o),
    .last_of_scan_o    (last_of_scan_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Binning predictor: own copy of registers, slot pointer, last angle and
  // the per-slot distance store.
  // ---------------------------------------------------------------------
  logic [BEAM_CNT_W-1:0] pm_count = BEAM_CNT_RST;
  logic [TOL_W-1:0]      pm_tol   = TOL_RST;
  logic [6:0]            pm_slot  = '0;
  logic [ANGLE_W-1:0]    pm_prev  = ANGLE_NONE;
  logic [DIST_W-1:0]     pm_store [MAX_BEAMS_DEF] = '{default: '0};
  int                    pred_scans = 0;

  bin_word_t scan_words_q [$];  // words still owed by the block, oldest first
  bin_word_t fresh_words  [$];  // words the last reading produced

  int send_idle_pct = 35;
  int recv_idle_pct = 66;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int n_errors      = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_scans       = 0;

  function automatic int live_count();
    int c;
    c = int'(pm_count);
    if (c == 0) c = 1;
    if (c > MAX_BEAMS_DEF) c = MAX_BEAMS_DEF;
    return c;
  endfunction

  function automatic int slot_target();
    return ((int'(pm_slot) + 1) * DEG_FULL) / live_count();
  endfunction

  // angular distance around the circle
  function automatic int arc_gap(int a, int b);
    int d;
    d = a - b;
    if (d < 0) d = -d;
    if (d > DEG_HALF) begin
      d = DEG_FULL - d;
      if (d < 0) d = -d;
    end
    return d;
  endfunction

  // open window, not wrapped at 360
  function automatic bit in_window(int a);
    int tgt;
    int t;
    tgt = slot_target();
    t   = int'(pm_tol);
    return (a > tgt - t) && (a < tgt + t);
  endfunction

  function automatic void bin_reading(logic [ANGLE_W-1:0] ang, logic [DIST_W-1:0] rng);
    int a;
    int tgt;
    int c;
    a   = int'(ang);
    tgt = slot_target();
    if (in_window(a)) begin
      if (arc_gap(tgt, a) < arc_gap(int'(pm_prev), a)) begin
        pm_store[pm_slot[SLOT_W-1:0]] = rng;
        pm_prev = ang;
      end else begin
        pm_slot = pm_slot + 7'd1;
      end
    end
    c = live_count();
    if (int'(pm_slot) >= c) begin
      pm_slot = '0;
      pm_prev = ANGLE_NONE;
      pred_scans++;
      for (int k = 0; k < c; k++) begin
        fresh_words.push_back('{SLOT_W'(k), pm_store[k], (k == c - 1)});
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one reading word; returns at the edge that accepts it.
  // Valid stays high on return so back-to-back words need no toggle.
  task automatic offer_word(input logic [ANGLE_W-1:0] ang, input logic [DIST_W-1:0] rng,
                            input bit known, input bin_word_t known_word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    reading_angle_i    <= ang;
    reading_distance_i <= rng;
    bin_reading(ang, rng);
    if (known) begin
      fresh_words.delete();
      scan_words_q.push_back(known_word);
    end else begin
      while (fresh_words.size() != 0) scan_words_q.push_back(fresh_words.pop_front());
    end
    n_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending, let every owed word drain, then let stray readings settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scan_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_BEAM_COUNT) pm_count = val[BEAM_CNT_W-1:0];
    else pm_tol = val[TOL_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed slot walks: a reading near the target (stores) and a
  // repeat of the last stored angle (advances), with some noise mixed in.
  // In sweep mode only the walk is used, hopping slots as fast as possible.
  task automatic pick_reading(input bit sweep, output logic [ANGLE_W-1:0] ang,
                              output logic [DIST_W-1:0] rng);
    int a;
    int t;
    int roll;
    int dsel;
    t    = int'(pm_tol);
    roll = int'($urandom_range(99));
    dsel = int'($urandom_range(15));
    if (dsel == 0) rng = '0;
    else if (dsel == 1) rng = '1;
    else rng = DIST_W'($urandom_range(65535));
    if (sweep) begin
      a = (pm_prev != ANGLE_NONE && in_window(int'(pm_prev))) ? int'(pm_prev) : slot_target();
    end else if (roll < 15) begin
      a = int'($urandom_range(511));
    end else if (roll < 55 || pm_prev == ANGLE_NONE) begin
      a = slot_target();
      if (t > 0) a = a + int'($urandom_range(2 * t - 2)) - (t - 1);
    end else begin
      a = int'(pm_prev);
    end
    if (a < 0) a = 0;
    if (a > 511) a = 511;
    ang = ANGLE_W'(a);
  endtask

  task automatic run_phase(input logic [BEAM_CNT_W-1:0] count, input logic [TOL_W-1:0] tol,
                           input int n_items, input bit sweep, input bit stall_rx,
                           input int pause_at);
    int k;
    int start;
    logic [ANGLE_W-1:0] ang;
    logic [DIST_W-1:0]  rng;
    wait_idle();
    cfg_write(CFG_BEAM_COUNT, CFG_DATA_W'(count));
    cfg_write(CFG_ANGLE_TOL, CFG_DATA_W'(tol));
    if (stall_rx) hold_req = 1'b1;
    start = pred_scans;
    for (k = 0; sweep ? (pred_scans == start && k < SWEEP_GUARD) : (k < n_items); k++) begin
      // sender waits out every owed word mid-phase
      if (k == pause_at) wait_idle();
      pick_reading(sweep, ang, rng);
      offer_word(ang, rng, 1'b0, NO_WORD);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold on request.
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest owed one.
  always @(posedge clk_i) begin
    bin_word_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (scan_words_q.size() == 0) begin
        $display("%0t: unexpected word: slot %0d dist %0d last %0b", $time,
                 slot_number_o, slot_distance_o, last_of_scan_o);
        n_errors++;
      end else begin
        want = scan_words_q.pop_front();
        n_checked++;
        if (last_of_scan_o) n_scans++;
        if (slot_number_o !== want.slot) begin
          $display("%0t: slot_number expected %0d got %0d", $time, want.slot, slot_number_o);
          n_errors++;
        end
        if (slot_distance_o !== want.distance) begin
          $display("%0t: slot_distance expected %0d got %0d", $time, want.distance,
                   slot_distance_o);
          n_errors++;
        end
        if (last_of_scan_o !== want.last) begin
          $display("%0t: last_of_scan expected %0b got %0b", $time, want.last,
                   last_of_scan_o);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t row;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles 35%, receiver 66%
    send_idle_pct = 35;
    recv_idle_pct = 66;
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.reg_sel, row.value);
      end else begin
        offer_word(row.angle, row.distance, row.kind == ROW_KNOWN, row.known);
      end
    end
    run_phase(BEAM_CNT_W'($urandom_range(6, 1)), TOL_W'($urandom_range(45, 3)), 15, 0, 0, -1);
    run_phase(7'd0, 6'd63, 15, 0, 0, -1);

    // swap: sender idles 66%, receiver 35%; one full 64-slot scan
    send_idle_pct = 66;
    recv_idle_pct = 35;
    run_phase(7'd64, 6'd45, 0, 1, 0, -1);
    run_phase(BEAM_CNT_W'($urandom_range(8, 2)), TOL_W'($urandom_range(45, 0)), 15, 0, 0, -1);

    // no idling; long receiver hold fills the block, then a mid-phase drain
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(7'd1, 6'd20, 20, 0, 1, -1);
    run_phase(BEAM_CNT_W'($urandom_range(8, 1)), TOL_W'($urandom_range(45, 0)), 15, 0, 0, 10);

    wait_idle();
    $display("sent %0d readings, checked %0d result words in %0d scans", n_sent, n_checked,
             n_scans);
    $display("counts 0..64 incl. saturation and mid-scan lowering, tolerance 0..63");
    if (n_errors == 0) begin
      $display("tb_lidar_scan_angle_binner_top OK");
    end else begin
      $display("tb_lidar_scan_angle_binner_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("timeout, %0d words still owed", scan_words_q.size());
    $display("tb_lidar_scan_angle_binner_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsab_pkg.sv
design/lsab_queue.sv
design/lsab_div.sv
design/lsab_engine.sv
design/lidar_scan_angle_binner_top.sv
design/lsab_checker.sv
sim/tb_lidar_scan_angle_binner_top.sv
